### rtl/pmt_pkg.sv
package pmt_pkg;

  // Operation codes carried by in_operation.
  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_MAP   = 2'd2;
  localparam logic [1:0] OP_FIND  = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_ABSENT = 2'd1;
  localparam logic [1:0] ST_FAIL   = 2'd2;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SIZE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_FRAMES = 1'd1;

  localparam int CFG_DATA_W   = 13;
  localparam int PAGE_W       = 13;
  localparam int NFRM_W       = 5;
  localparam int TAG_W        = 31;
  localparam int PROD_W       = TAG_W + PAGE_W;
  // Wide enough for any signed block bound at every parameter setting.
  localparam int SPAN_W       = 34;

endpackage

### rtl/paged_memory_translator.sv
// Paged memory translator: a fully associative table of physical page frames.
// Input words arrive on in_* (valid/stall) and each gives exactly one result
// word on out_* (valid/stall). The page size and the number of frames in use
// are written through cfg_* (valid/ready, always ready) while the block is idle;
// the user must ensure this; the block itself does not enforce it. One item is
// worked on at a time; in_stall is high from acceptance until its result has been
// placed in the output register. Read and write: the frame tags are searched
// in ascending order through the tag memory and one shared tag-times-page-size
// multiplier; each mapped frame is read, multiplied and compared (S_TAG_RD,
// S_TAG_MUL, S_TAG_CMP), each unmapped frame is skipped in S_TAG_RD. A write
// then ends in S_DONE, a read fetches its byte in S_BYTE, a miss goes to S_DONE.
// Map: writes the tag and zero-fills the frame through the byte store port,
// one byte a cycle, then hands its result to S_DONE.
// Find block: one frame is compared per cycle in ascending order, then the
// result goes to S_DONE.
// Failures detected on acceptance go straight to S_DONE.
// Reset clears the frame valid bits (all frames unmapped), sets page_size to
// 4096 and num_frames to zero; the byte store is not cleared. When the receiver
// stalls, the result word holds in the output register and the block waits
// with the next result, if any, before it accepts another word.
module paged_memory_translator
  import pmt_pkg::*;
#(
  parameter int MAX_FRAMES     = 16,
  parameter int MAX_PAGE_BYTES = 4096
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_operation,
  input  logic signed [31:0]    in_address,
  input  logic [7:0]            in_write_byte,
  input  logic [7:0]            in_frame_index,
  input  logic [30:0]           in_virtual_page,
  input  logic [12:0]           in_block_size,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            out_status,
  output logic [7:0]            out_read_byte,
  output logic [3:0]            out_found_frame,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int STORE_DEPTH = MAX_FRAMES * MAX_PAGE_BYTES;
  localparam int AW = STORE_DEPTH > 1 ? $clog2(STORE_DEPTH) : 1;
  localparam int IW = MAX_FRAMES > 1 ? $clog2(MAX_FRAMES) : 1;
  localparam int CW = $clog2(MAX_FRAMES + 1);
  localparam logic [PAGE_W-1:0] PS_CAP =
    PAGE_W'(MAX_PAGE_BYTES < 8191 ? MAX_PAGE_BYTES : 8191);
  localparam logic [AW-1:0] FRAME_STRIDE = AW'(MAX_PAGE_BYTES);

  typedef enum logic [2:0] {
    S_IDLE, S_TAG_RD, S_TAG_MUL, S_TAG_CMP, S_BYTE, S_FILL, S_BLOCK, S_DONE
  } state_t;

  // Configuration registers.
  logic [PAGE_W-1:0] page_size_r;
  logic [NFRM_W-1:0] num_frames_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_size_r  <= PAGE_W'(4096);
      num_frames_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PAGE_SIZE:  page_size_r  <= cfg_data[PAGE_W-1:0];
        CFG_NUM_FRAMES: num_frames_r <= cfg_data[NFRM_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective page size and frame count.
  logic [PAGE_W-1:0] ps;
  logic [CW-1:0]     n_eff;

  always_comb begin
    if (page_size_r == '0) begin
      ps = PAGE_W'(1);
    end else if (page_size_r > PS_CAP) begin
      ps = PS_CAP;
    end else begin
      ps = page_size_r;
    end
    if (32'(num_frames_r) > MAX_FRAMES) begin
      n_eff = CW'(MAX_FRAMES);
    end else begin
      n_eff = CW'(num_frames_r);
    end
  end

  state_t                   state_r, state_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [MAX_FRAMES-1:0]    valid_r, valid_nxt;
  logic [1:0]               op_r, op_nxt;
  logic [30:0]              addr_r, addr_nxt;
  logic [7:0]               wbyte_r, wbyte_nxt;
  logic signed [SPAN_W-1:0] addr_s_r, addr_s_nxt;
  logic signed [SPAN_W-1:0] bend_r, bend_nxt;
  logic signed [SPAN_W-1:0] left_r, left_nxt;
  logic signed [SPAN_W-1:0] right_r, right_nxt;
  logic [CW-1:0]            i_r, i_nxt;
  logic [AW-1:0]            base_r, base_nxt;
  logic [PAGE_W-1:0]        k_r, k_nxt;
  logic [PROD_W-1:0]        prod_r, prod_nxt;
  logic [1:0]               res_status_r, res_status_nxt;
  logic [7:0]               res_rbyte_r, res_rbyte_nxt;
  logic [3:0]               res_found_r, res_found_nxt;
  logic [1:0]               out_status_r, out_status_nxt;
  logic [7:0]               out_rbyte_r, out_rbyte_nxt;
  logic [3:0]               out_found_r, out_found_nxt;

  // Memory ports.
  logic              tag_we;
  logic [IW-1:0]     tag_waddr;
  logic [TAG_W-1:0]  tag_rdata;
  logic              st_we;
  logic [AW-1:0]     st_addr;
  logic [7:0]        st_wdata;
  logic [7:0]        st_rdata;

  // Tag window compare: the address lies in the frame when 0 <= addr - left < ps.
  logic signed [PROD_W:0] diff;
  logic                   tag_hit;

  assign diff    = $signed({(PROD_W + 1 - 31)'(0), addr_r}) - $signed({1'b0, prod_r});
  assign tag_hit = !diff[PROD_W] && (diff[PROD_W-1:0] < PROD_W'(ps));

  logic in_acc;
  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    out_valid_nxt  = out_valid_r;
    valid_nxt      = valid_r;
    op_nxt         = op_r;
    addr_nxt       = addr_r;
    wbyte_nxt      = wbyte_r;
    addr_s_nxt     = addr_s_r;
    bend_nxt       = bend_r;
    left_nxt       = left_r;
    right_nxt      = right_r;
    i_nxt          = i_r;
    base_nxt       = base_r;
    k_nxt          = k_r;
    prod_nxt       = prod_r;
    res_status_nxt = res_status_r;
    res_rbyte_nxt  = res_rbyte_r;
    res_found_nxt  = res_found_r;
    out_status_nxt = out_status_r;
    out_rbyte_nxt  = out_rbyte_r;
    out_found_nxt  = out_found_r;
    tag_we         = 1'b0;
    tag_waddr      = IW'(in_frame_index);
    st_we          = 1'b0;
    st_addr        = base_r + AW'(diff[PROD_W-1:0]);
    st_wdata       = wbyte_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_nxt         = in_operation;
          addr_nxt       = in_address[30:0];
          wbyte_nxt      = in_write_byte;
          addr_s_nxt     = SPAN_W'(in_address);
          bend_nxt       = SPAN_W'(in_address) + $signed(SPAN_W'(in_block_size))
                           - $signed(SPAN_W'(1));
          left_nxt       = '0;
          right_nxt      = $signed(SPAN_W'(ps)) - $signed(SPAN_W'(1));
          i_nxt          = '0;
          base_nxt       = '0;
          k_nxt          = '0;
          res_status_nxt = ST_ABSENT;
          res_rbyte_nxt  = '0;
          res_found_nxt  = '0;
          state_nxt      = S_DONE;
          case (in_operation)
            OP_READ, OP_WRITE: begin
              if (in_address[31]) begin
                res_status_nxt = ST_FAIL;
              end else if (n_eff != '0) begin
                state_nxt = S_TAG_RD;
              end
            end
            OP_MAP: begin
              if (n_eff == '0 || 32'(in_frame_index) >= 32'(n_eff)) begin
                res_status_nxt = ST_FAIL;
              end else begin
                tag_we    = 1'b1;
                valid_nxt[IW'(in_frame_index)] = 1'b1;
                base_nxt  = AW'(32'(in_frame_index) * MAX_PAGE_BYTES);
                state_nxt = S_FILL;
              end
            end
            default: begin
              if (in_block_size != '0 && n_eff != '0) begin
                state_nxt = S_BLOCK;
              end
            end
          endcase
        end
      end

      S_TAG_RD: begin
        if (i_r == n_eff) begin
          state_nxt = S_DONE;
        end else if (!valid_r[i_r[IW-1:0]]) begin
          i_nxt    = i_r + CW'(1);
          base_nxt = base_r + FRAME_STRIDE;
        end else begin
          state_nxt = S_TAG_MUL;
        end
      end

      S_TAG_MUL: begin
        prod_nxt  = tag_rdata * PROD_W'(ps);
        state_nxt = S_TAG_CMP;
      end

      S_TAG_CMP: begin
        if (tag_hit) begin
          res_status_nxt = ST_OK;
          if (op_r == OP_WRITE) begin
            st_we     = 1'b1;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_BYTE;
          end
        end else begin
          i_nxt     = i_r + CW'(1);
          base_nxt  = base_r + FRAME_STRIDE;
          state_nxt = S_TAG_RD;
        end
      end

      S_BYTE: begin
        res_rbyte_nxt = st_rdata;
        state_nxt     = S_DONE;
      end

      S_FILL: begin
        st_we    = 1'b1;
        st_addr  = base_r + AW'(k_r);
        st_wdata = '0;
        k_nxt    = k_r + PAGE_W'(1);
        if (k_r == ps - PAGE_W'(1)) begin
          res_status_nxt = ST_OK;
          state_nxt      = S_DONE;
        end
      end

      S_BLOCK: begin
        if (i_r == n_eff) begin
          state_nxt = S_DONE;
        end else if (left_r <= addr_s_r && bend_r <= right_r) begin
          res_status_nxt = ST_OK;
          res_found_nxt  = 4'(i_r);
          state_nxt      = S_DONE;
        end else begin
          i_nxt     = i_r + CW'(1);
          left_nxt  = left_r + $signed(SPAN_W'(ps));
          right_nxt = right_r + $signed(SPAN_W'(ps));
        end
      end

      S_DONE: begin
        // Wait for the output register to be free before handing over the word.
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_rbyte_nxt  = res_rbyte_r;
          out_found_nxt  = res_found_r;
          state_nxt      = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      valid_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      valid_r     <= valid_nxt;
    end
    op_r         <= op_nxt;
    addr_r       <= addr_nxt;
    wbyte_r      <= wbyte_nxt;
    addr_s_r     <= addr_s_nxt;
    bend_r       <= bend_nxt;
    left_r       <= left_nxt;
    right_r      <= right_nxt;
    i_r          <= i_nxt;
    base_r       <= base_nxt;
    k_r          <= k_nxt;
    prod_r       <= prod_nxt;
    res_status_r <= res_status_nxt;
    res_rbyte_r  <= res_rbyte_nxt;
    res_found_r  <= res_found_nxt;
    out_status_r <= out_status_nxt;
    out_rbyte_r  <= out_rbyte_nxt;
    out_found_r  <= out_found_nxt;
  end

  pmt_ram #(
    .WIDTH (TAG_W),
    .DEPTH (MAX_FRAMES)
  ) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (tag_waddr),
    .wdata (in_virtual_page),
    .raddr (i_r[IW-1:0]),
    .rdata (tag_rdata)
  );

  pmt_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_store_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_addr),
    .wdata (st_wdata),
    .raddr (st_addr),
    .rdata (st_rdata)
  );

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_read_byte   = out_rbyte_r;
  assign out_found_frame = out_found_r;

endmodule

### rtl/pmt_ram.sv
module pmt_ram
  import pmt_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/pmt_checker.sv
module pmt_checker
  import pmt_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] out_status,
  input logic [7:0] out_read_byte,
  input logic [3:0] out_found_frame
);

  // An accepted word takes the block out of idle, which closes the input.
  a_busy_after_accept: assert property (
    @(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall
  ) else $error("input accepted again in the cycle after a word was taken");

  a_status_code: assert property (
    @(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK || out_status == ST_ABSENT || out_status == ST_FAIL)
  ) else $error("result word carries an undefined status");

  a_fail_clean: assert property (
    @(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> (out_read_byte == '0 && out_found_frame == '0)
  ) else $error("unsuccessful result carries a nonzero byte or frame");

  a_out_hold: assert property (
    @(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_status)
                                  && $stable(out_read_byte) && $stable(out_found_frame))
  ) else $error("stalled result word changed");

endmodule

bind paged_memory_translator pmt_checker u_pmt_checker (.*);

### tb/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pmt_pkg::*;

  localparam int FRAMES_MAX = 16;
  localparam int PAGE_BYTES_MAX = 4096;
  localparam int QUIET_LIMIT = 20000;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] addr;
    logic [7:0]  wbyte;
    logic [7:0]  frame;
    logic [30:0] vpage;
    logic [12:0] bsize;
  } xlat_req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] rbyte;
    logic [3:0] frame;
  } xlat_resp_t;

  typedef struct packed {
    bit          is_cfg;
    bit          typed;
    logic [12:0] ps;
    logic [4:0]  nf;
    xlat_req_t   req;
    xlat_resp_t  resp;
  } stim_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [1:0]            in_operation;
  logic signed [31:0]    in_address;
  logic [7:0]            in_write_byte;
  logic [7:0]            in_frame_index;
  logic [30:0]           in_virtual_page;
  logic [12:0]           in_block_size;
  logic                  out_valid;
  logic                  out_stall;
  logic [1:0]            out_status;
  logic [7:0]            out_read_byte;
  logic [3:0]            out_found_frame;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  paged_memory_translator #(
    .MAX_FRAMES    (FRAMES_MAX),
    .MAX_PAGE_BYTES(PAGE_BYTES_MAX)
  ) DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_address     (in_address),
    .in_write_byte  (in_write_byte),
    .in_frame_index (in_frame_index),
    .in_virtual_page(in_virtual_page),
    .in_block_size  (in_block_size),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_read_byte  (out_read_byte),
    .out_found_frame(out_found_frame),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // Shadow copy of the translator state.
  logic [12:0] cur_page_size = 13'd4096;
  logic [4:0]  cur_num_frames = 5'd0;
  logic [30:0] page_tag [FRAMES_MAX];
  bit          tag_valid [FRAMES_MAX];
  logic [7:0]  frame_bytes [FRAMES_MAX*PAGE_BYTES_MAX];
  bit          byte_known [FRAMES_MAX*PAGE_BYTES_MAX];

  xlat_resp_t awaited_results [$];
  stim_row_t  stim_rows [$];

  int errors = 0;
  int items_sent = 0;
  int settings_done = 0;
  int send_idle = 0;
  int recv_idle = 0;
  int op_count [4];
  int status_count [4];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint page_bytes();
    if (cur_page_size == 0) return 1;
    if (cur_page_size > PAGE_BYTES_MAX) return PAGE_BYTES_MAX;
    return cur_page_size;
  endfunction

  function automatic int unsigned frames_used();
    if (cur_num_frames > FRAMES_MAX) return FRAMES_MAX;
    return cur_num_frames;
  endfunction

  // Lowest mapped frame covering a non-negative virtual address, or -1.
  function automatic int find_page(input longint a, output int unsigned where);
    longint ps;
    longint left;
    int unsigned n;
    int i;
    ps = page_bytes();
    n = frames_used();
    where = 0;
    for (i = 0; i < n; i++) begin
      if (tag_valid[i]) begin
        left = longint'(page_tag[i]) * ps;
        if (left <= a && a <= left + ps - 1) begin
          where = i * PAGE_BYTES_MAX + int'(a - left);
          return i;
        end
      end
    end
    return -1;
  endfunction

  function automatic xlat_resp_t translate_word(input xlat_req_t r);
    xlat_resp_t res;
    longint a;
    longint ps;
    longint left;
    longint bend;
    longint bsz;
    int unsigned n;
    int unsigned where;
    int unsigned base;
    int hit;
    int i;
    res.status = ST_ABSENT;
    res.rbyte = 8'd0;
    res.frame = 4'd0;
    a = longint'($signed(r.addr));
    ps = page_bytes();
    n = frames_used();
    case (r.op)
      OP_READ, OP_WRITE: begin
        if (a < 0) begin
          res.status = ST_FAIL;
        end else begin
          hit = find_page(a, where);
          if (hit >= 0) begin
            res.status = ST_OK;
            if (r.op == OP_READ) begin
              res.rbyte = frame_bytes[where];
            end else begin
              frame_bytes[where] = r.wbyte;
              byte_known[where] = 1'b1;
            end
          end
        end
      end
      OP_MAP: begin
        if (n == 0 || r.frame >= n) begin
          res.status = ST_FAIL;
        end else begin
          page_tag[r.frame[3:0]] = r.vpage;
          tag_valid[r.frame[3:0]] = 1'b1;
          base = r.frame * PAGE_BYTES_MAX;
          for (i = 0; i < ps; i++) begin
            frame_bytes[base + i] = 8'd0;
            byte_known[base + i] = 1'b1;
          end
          res.status = ST_OK;
        end
      end
      default: begin
        bsz = longint'(r.bsize);
        if (bsz != 0) begin
          bend = a + bsz - 1;
          for (i = 0; i < n && res.status != ST_OK; i++) begin
            left = i * ps;
            if (left <= a && bend <= left + ps - 1) begin
              res.status = ST_OK;
              res.frame = i[3:0];
            end
          end
        end
      end
    endcase
    return res;
  endfunction

  // Mostly well-aimed words: hits on mapped pages and blocks near frame edges.
  function automatic xlat_req_t random_request();
    xlat_req_t r;
    longint ps;
    longint a;
    int unsigned n;
    int unsigned f;
    int unsigned off;
    int map_pct;
    int pick;
    int roll;
    ps = page_bytes();
    n = frames_used();
    r.op = 2'($urandom_range(0, 3));
    r.addr = $urandom();
    r.wbyte = 8'($urandom());
    r.frame = 8'($urandom());
    r.vpage = 31'($urandom());
    r.bsize = 13'($urandom());
    if ($urandom_range(0, 99) < 8) return r;
    map_pct = (ps > 256) ? 10 : 18;
    pick = $urandom_range(0, 99);
    if (pick < map_pct) begin
      r.op = OP_MAP;
      if (n != 0 && $urandom_range(0, 99) < 85) r.frame = 8'($urandom_range(0, n - 1));
      roll = $urandom_range(0, 9);
      if (roll < 6) r.vpage = 31'($urandom_range(0, 7));
      else if (roll < 9) r.vpage = 31'($urandom_range(0, 32'h7FFF_FFFF / ps));
    end else if (pick < map_pct + 62) begin
      r.op = ($urandom_range(0, 99) < 55) ? OP_READ : OP_WRITE;
      f = (n == 0) ? 0 : $urandom_range(0, n - 1);
      roll = $urandom_range(0, 99);
      if (roll < 80 && n != 0 && tag_valid[f] &&
          longint'(page_tag[f]) * ps + ps - 1 <= 64'h7FFF_FFFF) begin
        a = longint'(page_tag[f]) * ps + $urandom_range(0, ps - 1);
        r.addr = a[31:0];
      end else if (roll < 92) begin
        r.addr = $urandom_range(0, 10 * ps);
      end
    end else begin
      r.op = OP_FIND;
      if ($urandom_range(0, 9) != 0) begin
        f = $urandom_range(0, FRAMES_MAX);
        off = $urandom_range(0, ps - 1);
        a = f * ps + off - (($urandom_range(0, 9) == 0) ? 1 : 0);
        r.addr = a[31:0];
        r.bsize = 13'($urandom_range(0, ps - off + 1));
      end
    end
    return r;
  endfunction

  function automatic void tab_cfg(input logic [12:0] ps, input logic [4:0] nf);
    stim_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.ps = ps;
    row.nf = nf;
    stim_rows.push_back(row);
  endfunction

  function automatic void tab_item(input bit typed, input logic [1:0] op,
                                   input logic [31:0] addr, input logic [7:0] wb,
                                   input logic [7:0] fr, input logic [30:0] vp,
                                   input logic [12:0] bs, input logic [1:0] st,
                                   input logic [7:0] rb, input logic [3:0] ff);
    stim_row_t row;
    row = '0;
    row.typed = typed;
    row.req.op = op;
    row.req.addr = addr;
    row.req.wbyte = wb;
    row.req.frame = fr;
    row.req.vpage = vp;
    row.req.bsize = bs;
    row.resp.status = st;
    row.resp.rbyte = rb;
    row.resp.frame = ff;
    stim_rows.push_back(row);
  endfunction

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_registers(input logic [12:0] ps, input logic [4:0] nf);
    wait_drain();
    cfg_valid <= 1'b1;
    cfg_index <= CFG_PAGE_SIZE;
    cfg_data <= ps;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    cur_page_size = ps;
    cfg_index <= CFG_NUM_FRAMES;
    cfg_data <= {8'd0, nf};
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    cur_num_frames = nf;
    cfg_valid <= 1'b0;
    settings_done++;
  endtask

  task automatic send_word(input xlat_req_t r, input bit typed, input xlat_resp_t typed_res);
    xlat_resp_t predicted;
    int unsigned where;
    int hit;
    if (items_sent < 350) begin
      send_idle = 36;
      recv_idle = 58;
    end else if (items_sent < 700) begin
      send_idle = 58;
      recv_idle = 36;
    end else begin
      send_idle = 0;
      recv_idle = 0;
    end
    // A read must never land on a byte that no map or write has set.
    if (r.op == OP_READ && !r.addr[31]) begin
      hit = find_page(longint'($signed(r.addr)), where);
      if (hit >= 0 && !byte_known[where]) r.op = OP_WRITE;
    end
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= r.op;
    in_address <= r.addr;
    in_write_byte <= r.wbyte;
    in_frame_index <= r.frame;
    in_virtual_page <= r.vpage;
    in_block_size <= r.bsize;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    predicted = translate_word(r);
    awaited_results.push_back(typed ? typed_res : predicted);
    op_count[r.op]++;
    items_sent++;
  endtask

  task automatic run_random(input logic [12:0] ps, input logic [4:0] nf, input int count);
    xlat_resp_t none;
    int j;
    none = '0;
    set_registers(ps, nf);
    for (j = 0; j < count; j++) send_word(random_request(), 1'b0, none);
  endtask

  initial begin : result_check
    xlat_resp_t want;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
        status_count[out_status]++;
        if (awaited_results.size() == 0) begin
          $error("result word with no expectation waiting: status %0d", out_status);
          errors++;
        end else begin
          want = awaited_results.pop_front();
          if (out_status !== want.status) begin
            $error("status mismatch: expected %0d, got %0d", want.status, out_status);
            errors++;
          end
          if (out_read_byte !== want.rbyte) begin
            $error("read_byte mismatch: expected 0x%02h, got 0x%02h",
                   want.rbyte, out_read_byte);
            errors++;
          end
          if (out_found_frame !== want.frame) begin
            $error("found_frame mismatch: expected %0d, got %0d",
                   want.frame, out_found_frame);
            errors++;
          end
        end
      end
      out_stall <= ($urandom_range(0, 99) < recv_idle);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid === 1'b1 && in_stall === 1'b0) ||
          (out_valid === 1'b1 && out_stall === 1'b0) ||
          (cfg_valid === 1'b1 && cfg_ready === 1'b1))
        quiet = 0;
      else
        quiet++;
    end
    $display("Timeout: no word moved for %0d cycles", QUIET_LIMIT);
    $display("Verification failed");
    $finish;
  end

  initial begin
    int j;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_operation <= OP_READ;
    in_address <= '0;
    in_write_byte <= '0;
    in_frame_index <= '0;
    in_virtual_page <= '0;
    in_block_size <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_PAGE_SIZE;
    cfg_data <= '0;

    // Straight after reset nothing is created, so every lookup misses or fails.
    tab_item(1, OP_READ,  32'd0,         8'h00, 8'd0, 31'd0, 13'd0, ST_ABSENT, 8'd0, 4'd0);
    tab_item(1, OP_WRITE, 32'd100,       8'hFF, 8'd0, 31'd0, 13'd0, ST_ABSENT, 8'd0, 4'd0);
    tab_item(1, OP_MAP,   32'd0,         8'h00, 8'd0, 31'd0, 13'd0, ST_FAIL,   8'd0, 4'd0);
    tab_item(1, OP_FIND,  32'd0,         8'h00, 8'd0, 31'd0, 13'd1, ST_ABSENT, 8'd0, 4'd0);
    tab_item(1, OP_READ,  32'h8000_0000, 8'h00, 8'd0, 31'd0, 13'd0, ST_FAIL,   8'd0, 4'd0);
    tab_cfg(13'd16, 5'd4);
    // Frames 0 and 3 share a tag; the lower one must win.
    tab_item(1, OP_MAP,   32'd0,         8'h00, 8'd0,   31'd2, 13'd0, ST_OK,   8'd0, 4'd0);
    tab_item(1, OP_MAP,   32'd0,         8'h00, 8'd3,   31'd2, 13'd0, ST_OK,   8'd0, 4'd0);
    tab_item(1, OP_MAP,   32'd0,         8'h00, 8'd4,   31'd1, 13'd0, ST_FAIL, 8'd0, 4'd0);
    tab_item(1, OP_MAP,   32'd0,         8'h00, 8'd255, 31'd1, 13'd0, ST_FAIL, 8'd0, 4'd0);
    tab_item(0, OP_WRITE, 32'd33,        8'hA5, 8'd0, 31'd0, 13'd0, ST_OK,     8'd0, 4'd0);
    tab_item(0, OP_READ,  32'd33,        8'h00, 8'd0, 31'd0, 13'd0, ST_OK,     8'd0, 4'd0);
    tab_item(0, OP_READ,  32'd47,        8'h00, 8'd0, 31'd0, 13'd0, ST_OK,     8'd0, 4'd0);
    tab_item(1, OP_READ,  32'd48,        8'h00, 8'd0, 31'd0, 13'd0, ST_ABSENT, 8'd0, 4'd0);
    tab_item(1, OP_MAP,   32'd0, 8'h00, 8'd1, 31'h7FFF_FFFF, 13'd0, ST_OK,     8'd0, 4'd0);
    tab_item(1, OP_READ,  32'h7FFF_FFFF, 8'h00, 8'd0, 31'd0, 13'd0, ST_ABSENT, 8'd0, 4'd0);
    tab_item(1, OP_WRITE, 32'hFFFF_FFFF, 8'h00, 8'd0, 31'd0, 13'd0, ST_FAIL,   8'd0, 4'd0);
    tab_item(0, OP_FIND,  32'd0,         8'h00, 8'd0, 31'd0, 13'd16, ST_OK,    8'd0, 4'd0);
    tab_item(0, OP_FIND,  32'd50,        8'h00, 8'd0, 31'd0, 13'd14, ST_OK,    8'd0, 4'd0);
    tab_item(1, OP_FIND,  32'd60,        8'h00, 8'd0, 31'd0, 13'd5,  ST_ABSENT, 8'd0, 4'd0);
    tab_item(1, OP_FIND,  32'd10,        8'h00, 8'd0, 31'd0, 13'd0,  ST_ABSENT, 8'd0, 4'd0);
    tab_item(1, OP_FIND,  32'hFFFF_FFFF, 8'h00, 8'd0, 31'd0, 13'h1FFF, ST_ABSENT, 8'd0, 4'd0);
    // A page size of zero behaves as one byte and too many frames clamp to the maximum.
    tab_cfg(13'd0, 5'd31);
    tab_item(1, OP_MAP,   32'd0,         8'h00, 8'd15, 31'd5, 13'd0, ST_OK,    8'd0, 4'd0);
    tab_item(0, OP_WRITE, 32'd5,         8'h00, 8'd0, 31'd0, 13'd0, ST_OK,     8'd0, 4'd0);
    tab_item(0, OP_READ,  32'd5,         8'h00, 8'd0, 31'd0, 13'd0, ST_OK,     8'd0, 4'd0);
    tab_item(0, OP_FIND,  32'd15,        8'h00, 8'd0, 31'd0, 13'd1, ST_OK,     8'd0, 4'd0);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (j = 0; j < stim_rows.size(); j++) begin
      if (stim_rows[j].is_cfg)
        set_registers(stim_rows[j].ps, stim_rows[j].nf);
      else
        send_word(stim_rows[j].req, stim_rows[j].typed, stim_rows[j].resp);
    end

    run_random(13'd16,   5'd4,  150);
    run_random(13'd1,    5'd16, 120);
    run_random(13'd0,    5'd3,  60);
    run_random(13'd7,    5'd1,  80);
    run_random(13'd100,  5'd8,  120);
    run_random(13'd4096, 5'd16, 30);
    run_random(13'd8191, 5'd31, 25);
    run_random(13'd3,    5'd0,  40);
    run_random(13'd64,   5'd16, 150);
    run_random(13'd2,    5'd31, 120);
    run_random(13'd13,   5'd5,  155);

    wait_drain();
    repeat (20) @(posedge clk);
    if (awaited_results.size() != 0) begin
      $error("%0d expected result words never arrived", awaited_results.size());
      errors++;
    end

    $display("Sent %0d words (%0d reads, %0d writes, %0d maps, %0d block finds)",
             items_sent, op_count[OP_READ], op_count[OP_WRITE], op_count[OP_MAP],
             op_count[OP_FIND]);
    $display("under %0d settings; results returned: %0d ok, %0d absent, %0d failed.",
             settings_done, status_count[ST_OK], status_count[ST_ABSENT],
             status_count[ST_FAIL]);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
